// File: hdl/gbme_pkg.sv
// Shared types and operation codes for the 8x8 glyph editor.
// No dependencies; imported by gbme_alu and glyph_8x8_bit_matrix_editor.
`timescale 1ns / 1ps

package gbme_pkg;

	localparam int GLYPH_W = 64;

	// Operation codes carried in the input tuser field
	localparam logic [3:0] OP_LOAD       = 4'd0;
	localparam logic [3:0] OP_TOGGLE     = 4'd1;
	localparam logic [3:0] OP_INVERT     = 4'd2;
	localparam logic [3:0] OP_CLEAR      = 4'd3;
	localparam logic [3:0] OP_UNDO       = 4'd4;
	localparam logic [3:0] OP_RESTORE    = 4'd5;
	localparam logic [3:0] OP_COPY       = 4'd6;
	localparam logic [3:0] OP_PASTE      = 4'd7;
	localparam logic [3:0] OP_MIRROR_ROW = 4'd8;
	localparam logic [3:0] OP_MIRROR_BIT = 4'd9;
	localparam logic [3:0] OP_ROTATE     = 4'd10;
	localparam logic [3:0] OP_UP         = 4'd11;
	localparam logic [3:0] OP_DOWN       = 4'd12;
	localparam logic [3:0] OP_RIGHT      = 4'd13;
	localparam logic [3:0] OP_LEFT       = 4'd14;
	localparam logic [3:0] OP_SET_ROW    = 4'd15;

	localparam logic [GLYPH_W-1:0] LO7_MASK = 64'h7F7F_7F7F_7F7F_7F7F;
	localparam logic [GLYPH_W-1:0] HI1_MASK = 64'h8080_8080_8080_8080;
	localparam logic [GLYPH_W-1:0] HI7_MASK = 64'hFEFE_FEFE_FEFE_FEFE;
	localparam logic [GLYPH_W-1:0] LO1_MASK = 64'h0101_0101_0101_0101;

	typedef struct packed {
		logic [3:0]         func;
		logic [2:0]         row_index;
		logic [2:0]         column_index;
		logic [7:0]         row_value;
		logic [GLYPH_W-1:0] glyph_data;
	} item_t;

endpackage

// File: hdl/gbme_alu.sv
// Next-glyph logic: one operation applied to the current glyph.
// Depends on gbme_pkg.
`timescale 1ns / 1ps

module gbme_alu (
	input  gbme_pkg::item_t                 item,
	input  logic [gbme_pkg::GLYPH_W-1:0]   cur_glyph,
	input  logic [gbme_pkg::GLYPH_W-1:0]   undo_glyph,
	input  logic [gbme_pkg::GLYPH_W-1:0]   clip_glyph,
	output logic [gbme_pkg::GLYPH_W-1:0]   glyph_next
);
	import gbme_pkg::*;

	logic [GLYPH_W-1:0] swapped;
	logic [GLYPH_W-1:0] reversed;
	logic [GLYPH_W-1:0] rotated;
	logic [5:0]         toggle_pos;
	logic [5:0]         row_shift;

	// pixel (r,c) sits at bit 63 - (8r + c)
	assign toggle_pos = ~{item.row_index, item.column_index};
	assign row_shift  = {~item.row_index, 3'b000};

	always_comb begin
		for (int r = 0; r < 8; r++) begin
			swapped[8*(7-r) +: 8] = cur_glyph[8*r +: 8];
			for (int b = 0; b < 8; b++) begin
				reversed[8*r + b] = cur_glyph[8*r + 7 - b];
			end
		end
	end

	// clockwise: new(r,c) = old(7-c, r)
	always_comb begin
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				rotated[63 - 8*r - c] = cur_glyph[63 - 8*(7-c) - r];
			end
		end
	end

	always_comb begin
		unique case (item.func)
			OP_LOAD:       glyph_next = item.glyph_data;
			OP_TOGGLE:     glyph_next = cur_glyph ^ (64'd1 << toggle_pos);
			OP_INVERT:     glyph_next = ~cur_glyph;
			OP_CLEAR:      glyph_next = '0;
			OP_UNDO:       glyph_next = undo_glyph;
			OP_RESTORE:    glyph_next = item.glyph_data;
			OP_COPY:       glyph_next = cur_glyph;
			OP_PASTE:      glyph_next = clip_glyph;
			OP_MIRROR_ROW: glyph_next = swapped;
			OP_MIRROR_BIT: glyph_next = reversed;
			OP_ROTATE:     glyph_next = rotated;
			OP_UP:         glyph_next = {cur_glyph[55:0], cur_glyph[63:56]};
			OP_DOWN:       glyph_next = {cur_glyph[7:0], cur_glyph[63:8]};
			OP_RIGHT:      glyph_next = ((cur_glyph >> 1) & LO7_MASK)
			                          | ((cur_glyph << 7) & HI1_MASK);
			OP_LEFT:       glyph_next = ((cur_glyph << 1) & HI7_MASK)
			                          | ((cur_glyph >> 7) & LO1_MASK);
			OP_SET_ROW:    glyph_next = (cur_glyph & ~(64'hFF << row_shift))
			                          | ({56'd0, item.row_value} << row_shift);
		endcase
	end

endmodule

// File: hdl/glyph_8x8_bit_matrix_editor.sv
// Top level of the 8x8 one-bit glyph editor: input register, next-glyph
// logic, glyph/undo/clipboard state and output register. Uses gbme_pkg, gbme_alu.
`timescale 1ns / 1ps

// Usage
// The slave channel (s_*) takes one edit item per handshake: s_tuser holds the
// operation code, s_tdata the row, column, row byte and a full glyph. Each
// accepted item produces exactly one item on the master channel (m_*), whose
// tdata is the whole 64-bit glyph after the operation (row 0 in bits 63:56,
// bit 7 of a row is the leftmost pixel).
// An accepted item first waits in the input register; then the edit is applied
// and the result lands in the output register, which drives m_tvalid.
// With m_tready held high an item is taken every cycle; the state
// registers are written in the same cycle as the output register, so the next
// item always sees the previous item's glyph.
// When the receiver stalls, the finished item waits in the output register
// and one more item is held in the input register; s_tready then drops until
// the output is taken.
// Reset clears the glyph, the undo copy and the clipboard to zero and empties
// both registers.

module glyph_8x8_bit_matrix_editor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // row_index[2:0], column_index[5:3], row_value[13:6],
	                               // glyph_data[77:14], zero pad[79:78]
	input  logic [3:0]  s_tuser,   // func[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // glyph_out[63:0]
);
	import gbme_pkg::*;

	logic               valid_s1;
	item_t              item_s1;
	logic               out_valid_q;
	logic [GLYPH_W-1:0] out_data_q;
	logic [GLYPH_W-1:0] cur_q;
	logic [GLYPH_W-1:0] undo_q;
	logic [GLYPH_W-1:0] clip_q;
	logic [GLYPH_W-1:0] glyph_next;
	logic               advance;
	logic               fire;
	logic               s_accept;

	// move the held item on when the output register is free or being drained
	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.func         <= s_tuser;
			item_s1.row_index    <= s_tdata[2:0];
			item_s1.column_index <= s_tdata[5:3];
			item_s1.row_value    <= s_tdata[13:6];
			item_s1.glyph_data   <= s_tdata[77:14];
		end
	end

	gbme_alu u_alu (
		.item       (item_s1),
		.cur_glyph  (cur_q),
		.undo_glyph (undo_q),
		.clip_glyph (clip_q),
		.glyph_next (glyph_next)
	);

	// glyph state: commit in step with the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			undo_q <= '0;
			clip_q <= '0;
		end else if (fire) begin
			cur_q <= glyph_next;
			if (item_s1.func == OP_LOAD) begin
				undo_q <= item_s1.glyph_data;
			end
			if (item_s1.func == OP_COPY) begin
				clip_q <= cur_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= glyph_next;
		end
	end

	// a result appears only for an item that was waiting in the input register
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result produced without a held item");

	// the shown result is always the live glyph
	a_out_is_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q == cur_q))
		else $error("output register and glyph state disagree");

	// load writes the undo copy
	a_load_undo: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.func == OP_LOAD) |=> (undo_q == $past(item_s1.glyph_data)))
		else $error("undo copy not taken on load");

	// copy leaves the glyph alone and fills the clipboard
	a_copy_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.func == OP_COPY) |=> (clip_q == $past(cur_q) && $stable(cur_q)))
		else $error("copy did not fill clipboard or changed glyph");

	// back-pressure only while an item is held
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled with room to spare");

endmodule
